// ----- rtl/fshm_pkg.sv -----
// ============================================================================
// fshm_pkg - shared types and constants for the flow signature hash block
// Mode codes, the CRC32C column matrix and the pipeline payload record.
// ============================================================================
package fshm_pkg;

    localparam logic [31:0] CRC_POLY  = 32'h82F6_3B78;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] HIGH_HALF = 32'hFFFF_0000;
    localparam logic [31:0] LOW_HALF  = 32'h0000_FFFF;

    typedef enum logic [1:0] {
        MODE_XOR   = 2'd0,
        MODE_DUAL  = 2'd1,
        MODE_FOLD  = 2'd2,
        MODE_SPLIT = 2'd3
    } hash_mode_t;

    typedef logic [31:0][31:0] crc_mat_t;

    // Column i is the 32-shift reflected CRC32C of a word holding only bit i.
    function automatic crc_mat_t crc_build();
        crc_mat_t    m;
        logic [31:0] c;
        for (int i = 0; i < 32; i++)
        begin
            c = 32'(1) << i;
            for (int b = 0; b < 32; b++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            m[i] = c;
        end
        return m;
    endfunction

    localparam crc_mat_t CRC_MAT = crc_build();

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port_num;
        logic [15:0] dst_port_num;
        logic [31:0] stored_signature;
        logic [31:0] acc_fwd;
        logic [31:0] acc_rev;
    } stage_t;

endpackage

// ----- rtl/flow_signature_hash_match_unit.sv -----
// ============================================================================
// flow_signature_hash_match_unit - symmetric connection signature and match
// Input channel (in_valid / in_stall): one 4-tuple plus the stored table
// signature per beat. Output channel (out_valid / out_stall): the nonzero
// signature and is_match per beat. Config channel (cfg_valid / cfg_ready,
// always ready): cfg_data[1:0] sets hash_mode; write only while idle.
// Pipeline: four CRC stages, each one word step per chain, then the output
// register (select, zero replacement, compare).
// Throughput: one beat per cycle while out_stall stays low; a new beat can
// enter while earlier ones are still in flight.
// Stall: each stage holds while the next one is full and held; bubbles
// close up, so in_stall rises only once every stage is occupied.
// Reset: all stage valids clear, hash_mode returns to plain XOR.
// ============================================================================
module flow_signature_hash_match_unit
    import fshm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port_num,
    input  logic [15:0] dst_port_num,
    input  logic [31:0] stored_signature,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] signature,
    output logic        is_match
);

    hash_mode_t  hash_mode_reg;

    logic        v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    stage_t      s1_reg, s2_reg, s3_reg, s4_reg;
    stage_t      s0_next, s1_next, s2_next, s3_next, s4_next;
    logic [31:0] signature_reg, signature_next;
    logic        is_match_reg, is_match_next;
    logic        rdy1, rdy2, rdy3, rdy4, rdy5;

    logic [31:0] c1f, c1r, c2f, c2r, c3f, c3r, c4f, c4r;
    logic [31:0] w1r_crc, w1r, w2r, w3f, w3r;
    logic [31:0] port2, port3;

    // ---- configuration: always ready, keep the low two bits ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hash_mode_reg <= MODE_XOR;
        else if (cfg_valid)
            hash_mode_reg <= hash_mode_t'(cfg_data[1:0]);
    end

    // ---- handshake chain: a stage advances when empty or when drained ------
    assign rdy5     = !out_valid_reg || !out_stall;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    // ---- stage 1: first word of each chain (folded word in fold mode) -----
    assign s0_next = '{src_addr:         src_addr,
                       dst_addr:         dst_addr,
                       src_port_num:     src_port_num,
                       dst_port_num:     dst_port_num,
                       stored_signature: stored_signature,
                       acc_fwd:          32'd0,
                       acc_rev:          32'd0};

    assign w1r_crc = (hash_mode_reg == MODE_FOLD) ? (src_addr ^ dst_addr) : dst_addr;
    assign w1r     = w1r_crc;

    fshm_crc_word u_crc1f (.crc_in(32'd0), .word(src_addr), .crc_out(c1f));
    fshm_crc_word u_crc1r (.crc_in(32'd0), .word(w1r),      .crc_out(c1r));

    always_comb
    begin
        s1_next         = s0_next;
        s1_next.acc_fwd = c1f;
        s1_next.acc_rev = c1r;
    end

    // ---- stage 2: second address word; fold mode finishes with the port ---
    assign port2 = {16'd0, s1_reg.src_port_num ^ s1_reg.dst_port_num};
    assign w2r   = (hash_mode_reg == MODE_FOLD) ? port2 : s1_reg.src_addr;

    fshm_crc_word u_crc2f (.crc_in(s1_reg.acc_fwd), .word(s1_reg.dst_addr), .crc_out(c2f));
    fshm_crc_word u_crc2r (.crc_in(s1_reg.acc_rev), .word(w2r),             .crc_out(c2r));

    always_comb
    begin
        s2_next         = s1_reg;
        s2_next.acc_fwd = c2f;
        s2_next.acc_rev = c2r;
    end

    // ---- stage 3: XORed port (dual) or first port word (split) ------------
    assign port3 = {16'd0, s2_reg.src_port_num ^ s2_reg.dst_port_num};
    assign w3f   = (hash_mode_reg == MODE_SPLIT) ? {16'd0, s2_reg.src_port_num} : port3;
    assign w3r   = (hash_mode_reg == MODE_SPLIT) ? {16'd0, s2_reg.dst_port_num} : port3;

    fshm_crc_word u_crc3f (.crc_in(s2_reg.acc_fwd), .word(w3f), .crc_out(c3f));
    fshm_crc_word u_crc3r (.crc_in(s2_reg.acc_rev), .word(w3r), .crc_out(c3r));

    always_comb
    begin
        s3_next = s2_reg;
        if (hash_mode_reg != MODE_FOLD)
        begin
            s3_next.acc_fwd = c3f;
            s3_next.acc_rev = c3r;
        end
    end

    // ---- stage 4: second port word, split mode only -----------------------
    fshm_crc_word u_crc4f (.crc_in(s3_reg.acc_fwd), .word({16'd0, s3_reg.dst_port_num}),
                           .crc_out(c4f));
    fshm_crc_word u_crc4r (.crc_in(s3_reg.acc_rev), .word({16'd0, s3_reg.src_port_num}),
                           .crc_out(c4r));

    always_comb
    begin
        s4_next = s3_reg;
        if (hash_mode_reg == MODE_SPLIT)
        begin
            s4_next.acc_fwd = c4f;
            s4_next.acc_rev = c4r;
        end
    end

    // ---- stage 5: select, replace zero, compare ----------------------------
    fshm_sig_final u_final (
        .mode  (hash_mode_reg),
        .st    (s4_reg),
        .sig   (signature_next),
        .match (is_match_next)
    );

    // ---- valid bits travel with the data ----------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg        <= in_valid;
            if (rdy2) v2_reg        <= v1_reg;
            if (rdy3) v3_reg        <= v2_reg;
            if (rdy4) v4_reg        <= v3_reg;
            if (rdy5) out_valid_reg <= v4_reg;
        end
    end

    // ---- payload: hold while the stage is held ----------------------------
    always_ff @(posedge clk)
    begin
        if (rdy1) s1_reg <= s1_next;
        if (rdy2) s2_reg <= s2_next;
        if (rdy3) s3_reg <= s3_next;
        if (rdy4) s4_reg <= s4_next;
        if (rdy5)
        begin
            signature_reg <= signature_next;
            is_match_reg  <= is_match_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign signature = signature_reg;
    assign is_match  = is_match_reg;

`ifndef SYNTHESIS
    a_sig_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> signature != 32'd0)
        else $error("signature of zero delivered");

    a_entry_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted beat did not reach stage 1");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && rdy5 |=> out_valid)
        else $error("stage 4 beat lost on the way to the output");

    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && v4_reg && out_valid && out_stall)
        else $error("input stalled while the pipeline had room");
`endif

endmodule

// ----- rtl/fshm_crc_word.sv -----
// ============================================================================
// fshm_crc_word - one CRC32C word step
// Applies the 32-bit linear CRC32C map to (crc ^ word) as a flat XOR network.
// ============================================================================
module fshm_crc_word
    import fshm_pkg::*;
(
    input  logic [31:0] crc_in,
    input  logic [31:0] word,
    output logic [31:0] crc_out
);

    logic [31:0] x;

    always_comb
    begin
        x       = crc_in ^ word;
        crc_out = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                crc_out = crc_out ^ CRC_MAT[i];
            end
        end
    end

endmodule

// ----- rtl/fshm_sig_final.sv -----
// ============================================================================
// fshm_sig_final - signature select, zero replacement and match compare
// Combines the CRC chains per mode (plain XOR in XOR mode) and compares against the stored form.
// ============================================================================
module fshm_sig_final
    import fshm_pkg::*;
(
    input  hash_mode_t  mode,
    input  stage_t      st,
    output logic [31:0] sig,
    output logic        match
);

    logic [31:0] port_w;
    logic [31:0] plain;
    logic [31:0] raw;
    logic [31:0] swapped;

    always_comb
    begin
        port_w = {16'd0, st.src_port_num ^ st.dst_port_num};
        plain  = st.src_addr ^ st.dst_addr ^ port_w;
        case (mode)
            MODE_DUAL:  raw = st.acc_fwd ^ st.acc_rev;
            MODE_FOLD:  raw = st.acc_rev;
            MODE_SPLIT: raw = (st.acc_fwd & HIGH_HALF) | (st.acc_rev >> 16);
            default:    raw = plain;
        endcase
        // split mode falls back to the plain XOR before the all-ones value
        if (raw != '0)
            sig = raw;
        else if (mode == MODE_SPLIT && plain != '0)
            sig = plain;
        else
            sig = ALL_ONES;
        swapped = {sig[15:0], sig[31:16]};
        match   = (st.stored_signature == sig) ||
                  (mode == MODE_SPLIT && st.stored_signature == swapped);
    end

endmodule

// ----- test/flow_signature_hash_match_unit_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// flow_signature_hash_match_unit_tb - self-checking bench for the signature unit
// Push connection tuples through the block in every hash mode, under random
// gaps on the input and random stalls on the output. Predict each signature
// and match flag in the bench and compare every output beat, in order.
// ============================================================================
module flow_signature_hash_match_unit_tb;

    import fshm_pkg::*;

    // Pipeline depth from the block's own description; used for the final settle.
    localparam int PIPE_LATENCY = 5;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] stored;
    } tuple_t;

    typedef struct packed {
        logic [31:0] signature;
        logic        is_match;
    } sig_result_t;

    // How the stored table signature of a tuple relates to its true signature.
    typedef enum int {
        STORE_RANDOM,
        STORE_EMPTY,
        STORE_EXACT,
        STORE_SWAPPED,
        STORE_NEAR
    } store_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = 32'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] src_addr = 32'd0;
    logic [31:0] dst_addr = 32'd0;
    logic [15:0] src_port_num = 16'd0;
    logic [15:0] dst_port_num = 16'd0;
    logic [31:0] stored_signature = 32'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] signature;
    logic        is_match;

    tuple_t      tuple_q [$];       // tuples waiting to be driven
    sig_result_t sig_expect_q [$];  // predicted output beats, oldest first
    hash_mode_t  cur_mode = MODE_XOR;
    int          idle_lvl = 0;      // 0: no idling, 1: light, 2: heavy
    int          in_gap = 0;
    int          stall_left = 0;
    int          errors = 0;
    bit          in_beat = 1'b0;

    flow_signature_hash_match_unit u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .src_addr         (src_addr),
        .dst_addr         (dst_addr),
        .src_port_num     (src_port_num),
        .dst_port_num     (dst_port_num),
        .stored_signature (stored_signature),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .signature        (signature),
        .is_match         (is_match)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Signature prediction
    // ------------------------------------------------------------------------

    // One reflected CRC32C word step, bit-serial, low byte first.
    function automatic logic [31:0] crc_step(logic [31:0] crc, logic [31:0] word);
        logic [31:0] c;
        int          b;
        c = crc ^ word;
        for (b = 0; b < 32; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Split-half value before any zero fallback: forward chain high half on
    // top, reverse chain high half below.
    function automatic logic [31:0] split_raw(logic [31:0] sa, logic [31:0] da,
                                              logic [15:0] sp, logic [15:0] dp);
        logic [31:0] fwd;
        logic [31:0] rev;
        fwd = crc_step(crc_step(crc_step(crc_step(32'd0, sa), da), {16'd0, sp}),
                       {16'd0, dp});
        rev = crc_step(crc_step(crc_step(crc_step(32'd0, da), sa), {16'd0, dp}),
                       {16'd0, sp});
        return (fwd & HIGH_HALF) | (rev >> 16);
    endfunction

    function automatic logic [31:0] flow_signature(hash_mode_t m, logic [31:0] sa,
                                                   logic [31:0] da, logic [15:0] sp,
                                                   logic [15:0] dp);
        logic [31:0] port;
        logic [31:0] sig;
        port = {16'd0, sp ^ dp};
        case (m)
            MODE_DUAL:
            begin
                sig = crc_step(crc_step(crc_step(32'd0, sa), da), port)
                    ^ crc_step(crc_step(crc_step(32'd0, da), sa), port);
            end
            MODE_FOLD:
            begin
                sig = crc_step(crc_step(32'd0, sa ^ da), port);
            end
            MODE_SPLIT:
            begin
                sig = split_raw(sa, da, sp, dp);
                // a zero split value falls back to the plain XOR signature first
                if (sig == 32'd0)
                    sig = sa ^ da ^ port;
            end
            default:
            begin
                sig = sa ^ da ^ port;
            end
        endcase
        if (sig == 32'd0)
            sig = ALL_ONES;
        return sig;
    endfunction

    // Split mode also accepts the half-swapped form of the stored signature.
    function automatic logic sig_match(hash_mode_t m, logic [31:0] sig,
                                       logic [31:0] stored);
        return (stored == sig) || (m == MODE_SPLIT && stored == {sig[15:0], sig[31:16]});
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // No idling at level 0; else mostly no gap or a short one, and a few long ones.
    function automatic int pick_gap(int lvl);
        int r;
        r = $urandom_range(99);
        if (lvl == 0)
            return 0;
        if (r < ((lvl == 1) ? 75 : 45))
            return 0;
        if (r < ((lvl == 1) ? 97 : 94))
            return $urandom_range(1, 4);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return ALL_ONES;
            2:       return 32'd1 << $urandom_range(31);
            3:       return ~(32'd1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_port();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd1 << $urandom_range(15);
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue one tuple; the stored signature is built from the active mode.
    task automatic push_tuple(input logic [31:0] sa, input logic [31:0] da,
                              input logic [15:0] sp, input logic [15:0] dp,
                              input store_kind_t kind);
        tuple_t      t;
        logic [31:0] sig;
        sig     = flow_signature(cur_mode, sa, da, sp, dp);
        t.src   = sa;
        t.dst   = da;
        t.sport = sp;
        t.dport = dp;
        case (kind)
            STORE_EMPTY:   t.stored = 32'd0;
            STORE_EXACT:   t.stored = sig;
            STORE_SWAPPED: t.stored = {sig[15:0], sig[31:16]};
            STORE_NEAR:    t.stored = sig ^ (32'd1 << $urandom_range(31));
            default:       t.stored = $urandom;
        endcase
        tuple_q.push_back(t);
    endtask

    task automatic load_random(input int n);
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        store_kind_t kind;
        int          k;
        int          r;
        for (k = 0; k < n; k++)
        begin
            sa = rand_word();
            r  = $urandom_range(7);
            da = (r == 0) ? sa : ((r == 1) ? ~sa : rand_word());
            sp = rand_port();
            dp = ($urandom_range(3) == 0) ? sp : rand_port();
            r  = $urandom_range(9);
            case (r)
                0, 1, 2: kind = STORE_EXACT;
                3:       kind = STORE_SWAPPED;
                4:       kind = STORE_EMPTY;
                5:       kind = STORE_NEAR;
                default: kind = STORE_RANDOM;
            endcase
            push_tuple(sa, da, sp, dp, kind);
            // now and then send the same connection seen from the other end
            if ($urandom_range(7) == 0)
                push_tuple(da, sa, dp, sp, kind);
        end
    endtask

    // Build a tuple whose split-half value is zero but whose plain XOR is not,
    // so the split mode takes its first fallback. The split value is linear in
    // the tuple bits, so solve for dst, sport and dport over GF(2) against a
    // random src.
    task automatic solve_split_zero(output logic [31:0] sa, output logic [31:0] da,
                                    output logic [15:0] sp, output logic [15:0] dp);
        logic [64:0] rows [32];   // [63:0] unknowns {dport, sport, dst}, [64] rhs
        logic [64:0] tmp;
        logic [63:0] x;
        logic [63:0] unit;
        logic [31:0] base;
        logic [31:0] col;
        int          pivot_col [32];
        int          rank;
        int          piv;
        int          i;
        int          j;
        int          r;
        bit          ok;
        ok = 1'b0;
        while (!ok)
        begin
            sa   = $urandom;
            base = split_raw(sa, 32'd0, 16'd0, 16'd0);
            for (i = 0; i < 32; i++)
                rows[i] = {base[i], 64'd0};
            for (j = 0; j < 64; j++)
            begin
                unit = 64'd1 << j;
                col  = split_raw(32'd0, unit[31:0], unit[47:32], unit[63:48]);
                for (i = 0; i < 32; i++)
                    rows[i][j] = col[i];
            end
            // reduce to row echelon form with every pivot column cleared
            rank = 0;
            for (j = 0; j < 64; j++)
            begin
                piv = -1;
                for (r = rank; r < 32; r++)
                    if (piv < 0 && rows[r][j])
                        piv = r;
                if (piv >= 0)
                begin
                    tmp        = rows[piv];
                    rows[piv]  = rows[rank];
                    rows[rank] = tmp;
                    for (i = 0; i < 32; i++)
                        if (i != rank && rows[i][j])
                            rows[i] = rows[i] ^ rows[rank];
                    pivot_col[rank] = j;
                    rank++;
                end
            end
            ok = 1'b1;
            for (r = rank; r < 32; r++)
                if (rows[r][64])
                    ok = 1'b0;
            // free unknowns random, then settle each pivot from its row
            x = {$urandom, $urandom};
            for (r = 0; r < rank; r++)
                x[pivot_col[r]] = 1'b0;
            for (r = 0; r < rank; r++)
                x[pivot_col[r]] = rows[r][64] ^ (^(rows[r][63:0] & x));
            da = x[31:0];
            sp = x[47:32];
            dp = x[63:48];
            ok = ok && split_raw(sa, da, sp, dp) == 32'd0
                    && (sa ^ da ^ {16'd0, sp ^ dp}) != 32'd0;
        end
    endtask

    // Write the mode register; only ever called with the block idle.
    task automatic write_mode(input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_mode = hash_mode_t'(data[1:0]);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= $urandom;
    endtask

    // Hold until every queued tuple has gone in and every beat has come out.
    task automatic drain();
        while (tuple_q.size() != 0 || in_valid || sig_expect_q.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: advance on the falling edge once the current beat is taken
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_tuples
        tuple_t t;
        if (rst_n && (!in_valid || in_beat))
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (tuple_q.size() != 0)
            begin
                t = tuple_q.pop_front();
                src_addr         <= t.src;
                dst_addr         <= t.dst;
                src_port_num     <= t.sport;
                dst_port_num     <= t.dport;
                stored_signature <= t.stored;
                in_valid         <= 1'b1;
                in_gap = pick_gap(idle_lvl);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Record each accepted input beat and queue its predicted result.
    always @(posedge clk)
    begin : take_tuples
        sig_result_t want;
        in_beat = rst_n && in_valid && !in_stall;
        if (in_beat)
        begin
            want.signature = flow_signature(cur_mode, src_addr, dst_addr,
                                            src_port_num, dst_port_num);
            want.is_match  = sig_match(cur_mode, want.signature, stored_signature);
            sig_expect_q.push_back(want);
        end
    end

    // Output back-pressure: random stall runs, none at idle level zero.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap(idle_lvl);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare every output beat with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_sigs
        sig_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sig_expect_q.size() == 0)
            begin
                $display("%0t: output beat with nothing expected, signature %h is_match %b",
                         $time, signature, is_match);
                errors++;
            end
            else
            begin
                want = sig_expect_q.pop_front();
                if (signature !== want.signature)
                begin
                    $display("%0t: signature expected %h, got %h",
                             $time, want.signature, signature);
                    errors++;
                end
                if (is_match !== want.is_match)
                begin
                    $display("%0t: is_match expected %b, got %b (signature %h)",
                             $time, want.is_match, is_match, want.signature);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : run_test
        logic [31:0] sa;
        logic [31:0] da;
        logic [15:0] sp;
        logic [15:0] dp;
        int          p;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset mode is plain XOR: check it without writing the register.
        idle_lvl = 0;
        push_tuple(32'd0, 32'd0, 16'd0, 16'd0, STORE_EXACT);          // zero -> all ones
        push_tuple(32'h1234_5678, 32'h1234_5678, 16'h0050, 16'h0050, STORE_EMPTY);
        push_tuple(ALL_ONES, 32'd0, 16'hFFFF, 16'd0, STORE_EXACT);
        push_tuple(32'd0, ALL_ONES, 16'd0, 16'hFFFF, STORE_NEAR);
        push_tuple($urandom, $urandom, 16'($urandom), 16'($urandom), STORE_RANDOM);
        load_random(150);
        drain();

        // Dual CRC: equal addresses cancel the two chains to zero.
        write_mode(32'(MODE_DUAL));
        idle_lvl = 1;
        sa = $urandom;
        push_tuple(sa, sa, 16'($urandom), 16'($urandom), STORE_EXACT);
        push_tuple(ALL_ONES, ALL_ONES, 16'hFFFF, 16'hFFFF, STORE_EXACT);
        push_tuple(32'd0, 32'd0, 16'd0, 16'd0, STORE_EXACT);
        push_tuple($urandom, $urandom, 16'($urandom), 16'($urandom), STORE_EMPTY);
        load_random(200);
        drain();

        // Folded CRC: folded address and port both zero give a zero CRC.
        write_mode(32'(MODE_FOLD));
        idle_lvl = 2;
        sa = $urandom;
        push_tuple(sa, sa, 16'h1F90, 16'h1F90, STORE_EXACT);
        push_tuple(ALL_ONES, ALL_ONES, 16'hFFFF, 16'hFFFF, STORE_EXACT);
        push_tuple($urandom, $urandom, 16'($urandom), 16'($urandom), STORE_SWAPPED);
        load_random(200);
        drain();

        // Split halves: both fallbacks, swapped-half matches and empty slots.
        write_mode(32'(MODE_SPLIT));
        idle_lvl = 1;
        push_tuple(32'd0, 32'd0, 16'd0, 16'd0, STORE_EXACT);
        solve_split_zero(sa, da, sp, dp);
        push_tuple(sa, da, sp, dp, STORE_EXACT);
        solve_split_zero(sa, da, sp, dp);
        push_tuple(sa, da, sp, dp, STORE_SWAPPED);
        push_tuple($urandom, $urandom, 16'($urandom), 16'($urandom), STORE_SWAPPED);
        push_tuple($urandom, $urandom, 16'($urandom), 16'($urandom), STORE_EXACT);
        push_tuple($urandom, $urandom, 16'($urandom), 16'($urandom), STORE_EMPTY);
        push_tuple(ALL_ONES, ALL_ONES, 16'hFFFF, 16'hFFFF, STORE_NEAR);
        load_random(250);
        drain();

        // Upper bits of the write data must be dropped.
        write_mode(32'hFFFF_FFFC);
        idle_lvl = 2;
        load_random(150);
        drain();

        write_mode(32'h8000_0003);
        idle_lvl = 0;
        load_random(150);
        drain();

        // A few more phases in random modes and idling levels.
        for (p = 0; p < 3; p++)
        begin
            write_mode($urandom);
            idle_lvl = $urandom_range(0, 2);
            load_random(170);
            drain();
        end

        // Let any stray beat surface before judging the run.
        repeat (PIPE_LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("flow_signature_hash_match_unit test passed");
        else
            $display("flow_signature_hash_match_unit test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("flow_signature_hash_match_unit test failed");
        $finish;
    end

endmodule
